// File: hdl/lffc_pkg.sv
// Package for the legacy float format converter.
// Holds mode codes, field widths and the leading-zero helper. No dependencies.
package lffc_pkg;

    localparam int ModeW = 3;
    localparam int DataW = 64;

    localparam logic [ModeW-1:0] MODE_DEC_F = 3'd0;
    localparam logic [ModeW-1:0] MODE_DEC_D = 3'd1;
    localparam logic [ModeW-1:0] MODE_DEC_G = 3'd2;
    localparam logic [ModeW-1:0] MODE_ENC_F = 3'd3;
    localparam logic [ModeW-1:0] MODE_ENC_D = 3'd4;
    localparam logic [ModeW-1:0] MODE_ENC_G = 3'd5;

    localparam logic [22:0] FRAC23_ONES = 23'h7FFFFF;
    localparam logic [54:0] FRAC55_ONES = 55'h7FFFFFFFFFFFFF;
    localparam logic [51:0] FRAC52_ONES = 52'hFFFFFFFFFFFFF;

    // Position of the highest set bit of a 52-bit fraction (0 when none).
    function automatic logic [5:0] msb_pos52(input logic [51:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 52; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

endpackage

// File: hdl/lffc_core.sv
// Combinational conversion of one word between legacy and IEEE double bits.
// Depends on lffc_pkg.
module lffc_core import lffc_pkg::*; (
    input  logic [ModeW-1:0] mode,
    input  logic [DataW-1:0] data_in,
    output logic [DataW-1:0] data_out
);

    logic [63:0] dec_f, dec_d, dec_g, enc_f, enc_d, enc_g;

    // F decode
    logic [7:0] fe;
    assign fe    = data_in[30:23];
    assign dec_f = (fe == 8'd0) ? 64'd0 :
                   {data_in[31], 11'(fe) + 11'd894, data_in[22:0], 29'd0};

    // D decode with nearest-even rounding
    logic [7:0]  de;
    logic [51:0] dkeep;
    logic [2:0]  drem;
    logic        dinc;
    logic [62:0] dsum;
    assign de    = data_in[62:55];
    assign dkeep = data_in[54:3];
    assign drem  = data_in[2:0];
    assign dinc  = (drem > 3'd4) || (drem == 3'd4 && dkeep[0]);
    assign dsum  = {11'(de) + 11'd894, 52'd0} + {11'd0, dkeep} + 63'(dinc);
    assign dec_d = (de == 8'd0) ? 64'd0 : {data_in[63], dsum};

    // G decode, subnormal results for exponents 1 and 2
    logic [10:0] ge;
    logic [52:0] gv, gkeep;
    logic        gsh2, ginc;
    assign ge    = data_in[62:52];
    assign gv    = {1'b1, data_in[51:0]};
    assign gsh2  = (ge == 11'd1);
    assign gkeep = gsh2 ? (gv >> 2) : (gv >> 1);
    assign ginc  = gsh2 ? ((gv[1:0] > 2'd2) || (gv[1:0] == 2'd2 && gkeep[0]))
                        : (gv[0] && gkeep[0]);
    always_comb begin
        if (ge == 11'd0) dec_g = 64'd0;
        else if (ge >= 11'd3) dec_g = {data_in[63], ge - 11'd2, data_in[51:0]};
        else dec_g = {data_in[63], 10'd0, gkeep + 53'(ginc)};
    end

    // Encode: find exact exponent, normalize subnormals
    logic        es;
    logic [10:0] ex;
    logic [51:0] fr, frac;
    logic [5:0]  p;
    logic signed [12:0] ue;
    logic signed [12:0] ebf, ebg;
    logic [7:0]  ebf8;
    logic [10:0] ebg11;
    logic [23:0] mr;
    logic [22:0] mf;
    logic        is_zero, is_inf;
    assign es = data_in[63];
    assign ex = data_in[62:52];
    assign fr = data_in[51:0];
    assign p  = msb_pos52(fr);
    assign is_zero = (ex == 11'd0) && (fr == 52'd0);
    assign is_inf  = (ex == 11'h7FF);
    always_comb begin
        if (ex == 11'd0) begin
            frac = (fr << (7'd52 - 7'(p)));
            ue   = 13'(p) - 13'sd1074;
        end else begin
            frac = fr;
            ue   = 13'(ex) - 13'sd1023;
        end
    end
    assign ebf   = ue + 13'sd129;
    assign ebg   = ue + 13'sd1025;
    assign ebf8  = (ebf < 13'sd1) ? 8'd1 : (ebf > 13'sd255) ? 8'd255 : ebf[7:0];
    assign ebg11 = (ebg < 13'sd1) ? 11'd1 : (ebg > 13'sd2047) ? 11'd2047 : ebg[10:0];
    assign mr    = {1'b0, frac[51:29]} + 24'(frac[28]);
    assign mf    = mr[23] ? FRAC23_ONES : mr[22:0];

    always_comb begin
        if (is_zero) begin
            enc_f = '0; enc_d = '0; enc_g = '0;
        end else if (is_inf) begin
            enc_f = {32'd0, es, 8'hFF, FRAC23_ONES};
            enc_d = {es, 8'hFF, FRAC55_ONES};
            enc_g = {es, 11'h7FF, FRAC52_ONES};
        end else begin
            enc_f = {32'd0, es, ebf8, mf};
            enc_d = {es, ebf8, frac, 3'd0};
            enc_g = {es, ebg11, frac};
        end
    end

    // Select by mode
    always_comb begin
        case (mode)
            MODE_DEC_F: data_out = dec_f;
            MODE_DEC_D: data_out = dec_d;
            MODE_DEC_G: data_out = dec_g;
            MODE_ENC_F: data_out = enc_f;
            MODE_ENC_D: data_out = enc_d;
            MODE_ENC_G: data_out = enc_g;
            default:    data_out = '0;
        endcase
    end

endmodule

// File: hdl/legacy_float_format_converter_unit.sv
// Top level of the legacy float format converter: input register, core, output register.
// Depends on lffc_pkg and lffc_core.
//
// Usage:
//   The slave channel carries one word per transfer: tuser holds the mode
//   (F/D/G decode or encode), tdata the 64-bit word. The master channel
//   returns one 64-bit word per accepted input.
//   An input transfer loads the input register; the output register then
//   loads the converted word through the conversion logic once it is empty
//   or being read, and m_axis_tvalid rises when it is loaded. Throughput is
//   one word per cycle while the receiver does not stall, set by the
//   single conversion path between the two registers.
//   Reset (aresetn low, synchronous) empties both registers; no result is
//   pending afterwards.
//   When the receiver stalls, the output register holds its word, the input
//   register still takes one more word, and s_axis_tready then drops until
//   the output register drains.
module legacy_float_format_converter_unit import lffc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DataW-1:0]  s_axis_tdata,   // [63:0] data_in
    input  logic [ModeW-1:0]  s_axis_tuser,   // [2:0] mode
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DataW-1:0]  m_axis_tdata    // [63:0] data_out
);

    logic             in_valid_reg;
    logic [ModeW-1:0] in_mode_reg;
    logic [DataW-1:0] in_data_reg;
    logic             out_valid_reg;
    logic [DataW-1:0] out_data_reg;
    logic [DataW-1:0] conv_next;
    logic             out_load;

    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;

    // Input register: take a transfer whenever it frees up
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_mode_reg <= s_axis_tuser;
            in_data_reg <= s_axis_tdata;
        end
    end

    lffc_core u_core (
        .mode     (in_mode_reg),
        .data_in  (in_data_reg),
        .data_out (conv_next)
    );

    // Output register: hold while stalled, advance on load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (out_load) begin
            out_data_reg <= conv_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A stalled result must keep its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A pending input item is never dropped
    a_in_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_load |=> in_valid_reg)
        else $error("input item lost");

    // Loading the output always comes from a valid input item
    a_load_src: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> in_valid_reg)
        else $error("output loaded without input");

endmodule

// File: tb/sv/legacy_float_format_converter_unit_tb.sv
// Testbench for the legacy float format converter: random and directed F/D/G
// decode and encode words plus unused modes, checked against an in-bench conversion predictor.
// Depends on lffc_pkg and the legacy_float_format_converter_unit RTL.
module legacy_float_format_converter_unit_tb;
    import lffc_pkg::*;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [DataW-1:0] word;
    } conv_item_t;

    localparam int CycleLimit = 200000;
    localparam logic [ModeW-1:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [ModeW-1:0] MODE_UNUSED_7 = 3'd7;

    logic             aclk;
    logic             aresetn;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [DataW-1:0] s_axis_tdata;
    logic [ModeW-1:0] s_axis_tuser;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [DataW-1:0] m_axis_tdata;

    conv_item_t       pending_words[$];
    logic [DataW-1:0] expected_words[$];
    int               mismatches;
    int               cycles;
    int               words_checked;
    int               mode_count[8];
    bit               stim_done;
    bit               calm;

    legacy_float_format_converter_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        aclk = 1'b1; #4;
        aclk = 1'b0; #4;
    end

    // Encode IEEE double bits into F (kind 0), D (1) or G (2).
    function automatic logic [63:0] encode_word(logic [63:0] w, int kind);
        logic        s;
        logic [10:0] ex;
        logic [51:0] fr, frac;
        logic [53:0] rnd;
        logic [22:0] mant;
        int          p, e_true, eb;
        s  = w[63];
        ex = w[62:52];
        fr = w[51:0];
        if (ex == 11'd0 && fr == 52'd0) return 64'd0;
        if (ex == 11'h7FF) begin
            if (kind == 0) return {32'd0, s, 8'hFF, FRAC23_ONES};
            if (kind == 1) return {s, 8'hFF, FRAC55_ONES};
            return {s, 11'h7FF, FRAC52_ONES};
        end
        if (ex == 11'd0) begin
            p = 51;
            while (p > 0 && !fr[p]) p--;
            frac   = fr << (52 - p);
            e_true = p - 1074;
        end else begin
            frac   = fr;
            e_true = int'(ex) - 1023;
        end
        if (kind == 2) begin
            eb = e_true + 1025;
            if (eb < 1) eb = 1;
            if (eb > 2047) eb = 2047;
            return {s, eb[10:0], frac};
        end
        eb = e_true + 129;
        if (eb < 1) eb = 1;
        if (eb > 255) eb = 255;
        if (kind == 1) return {s, eb[7:0], frac, 3'b000};
        // F: round half away from zero, saturate the fraction without carry
        rnd = ({2'b00, frac} + 54'(1) * (54'd1 << 28)) >> 29;
        mant = (rnd > 54'h7FFFFF) ? FRAC23_ONES : rnd[22:0];
        return {32'd0, s, eb[7:0], mant};
    endfunction

    // Expected converter output for one mode/word pair.
    function automatic logic [63:0] convert_word(conv_item_t it);
        logic [63:0] w;
        logic [10:0] e;
        logic [52:0] v;
        logic [52:0] keep;
        logic [1:0]  rem;
        int          sh;
        w = it.word;
        case (it.mode)
            MODE_DEC_F: begin
                if (w[30:23] == 8'd0) return 64'd0;
                return {w[31], 11'(w[30:23]) + 11'd894, w[22:0], 29'd0};
            end
            MODE_DEC_D: begin
                if (w[62:55] == 8'd0) return 64'd0;
                keep = {1'b0, w[54:3]};
                if (w[2:0] > 3'd4 || (w[2:0] == 3'd4 && keep[0])) keep++;
                return {w[63], ({11'(w[62:55]) + 11'd894, 52'd0} + 63'(keep))};
            end
            MODE_DEC_G: begin
                e = w[62:52];
                if (e == 11'd0) return 64'd0;
                if (e >= 11'd3) return {w[63], e - 11'd2, w[51:0]};
                sh   = 3 - int'(e);
                v    = {1'b1, w[51:0]};
                keep = v >> sh;
                rem  = (sh == 1) ? {1'b0, v[0]} : v[1:0];
                if ((sh == 1 && (rem > 2'd1 || (rem == 2'd1 && keep[0]))) ||
                    (sh == 2 && (rem > 2'd2 || (rem == 2'd2 && keep[0])))) keep++;
                return {w[63], 10'd0, keep};
            end
            MODE_ENC_F: return encode_word(w, 0);
            MODE_ENC_D: return encode_word(w, 1);
            MODE_ENC_G: return encode_word(w, 2);
            default:    return 64'd0;
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random double bits biased toward zero, subnormal, inf/NaN and clamp edges.
    function automatic logic [63:0] rand_double();
        logic [63:0] w;
        w = rand64();
        case ($urandom_range(0, 9))
            0: w[62:52] = 11'd0;
            1: w[62:52] = 11'h7FF;
            2: w[62:52] = 11'($urandom_range(0, 20)) + 11'd880;
            3: w[62:52] = 11'($urandom_range(0, 20)) + 11'd1140;
            4: w[62:52] = 11'($urandom_range(0, 4)) + 11'd22;
            5: w[51:0]  = {23'h7FFFFF, 1'b1, 28'($urandom())};
            6: w[62:0]  = {11'd0, 52'd1 << $urandom_range(0, 51)};
            default: ;
        endcase
        return w;
    endfunction

    // Random legacy pattern biased toward zero and tiny exponents and tie bits.
    function automatic logic [63:0] rand_legacy(logic [ModeW-1:0] mode);
        logic [63:0] w;
        w = rand64();
        case ($urandom_range(0, 7))
            0: begin w[62:52] = 11'd0; w[30:23] = 8'd0; w[62:55] = 8'd0; end
            1: w[62:52] = 11'($urandom_range(1, 3));
            2: w[2:0] = 3'($urandom_range(3, 5));
            3: w[54:0] = FRAC55_ONES;
            4: begin w[62:55] = 8'hFF; w[30:23] = 8'hFF; end
            default: ;
        endcase
        if (mode == MODE_DEC_F && $urandom_range(0, 1)) w[63:32] = $urandom();
        return w;
    endfunction

    task automatic queue_word(logic [ModeW-1:0] mode, logic [63:0] w);
        conv_item_t it;
        it.mode = mode;
        it.word = w;
        pending_words.push_back(it);
    endtask

    // Directed corners, then random words across all modes.
    initial begin
        logic [ModeW-1:0] m;
        queue_word(MODE_DEC_F, 64'hFFFF_FFFF_007F_FFFF);
        queue_word(MODE_DEC_F, 64'h0000_0000_FFFF_FFFF);
        queue_word(MODE_DEC_D, 64'h0080_0000_0000_0004);
        queue_word(MODE_DEC_D, 64'h0080_0000_0000_000C);
        queue_word(MODE_DEC_D, 64'h7FFF_FFFF_FFFF_FFFF);
        queue_word(MODE_DEC_D, 64'h8000_0000_0000_0005);
        queue_word(MODE_DEC_G, 64'h0010_0000_0000_0001);
        queue_word(MODE_DEC_G, 64'h802F_FFFF_FFFF_FFFF);
        queue_word(MODE_DEC_G, 64'h001F_FFFF_FFFF_FFFE);
        queue_word(MODE_DEC_G, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(MODE_ENC_F, 64'h8000_0000_0000_0000);
        queue_word(MODE_ENC_F, 64'h3FF0_0000_1000_0000);
        queue_word(MODE_ENC_F, 64'hBFFF_FFFF_FFFF_FFFF);
        queue_word(MODE_ENC_F, 64'h7FF0_0000_0000_0000);
        queue_word(MODE_ENC_F, 64'h0000_0000_0000_0001);
        queue_word(MODE_ENC_D, 64'hFFF8_0000_0000_0001);
        queue_word(MODE_ENC_D, 64'h7FEF_FFFF_FFFF_FFFF);
        queue_word(MODE_ENC_D, 64'h000F_FFFF_FFFF_FFFF);
        queue_word(MODE_ENC_G, 64'h0000_0000_0000_0000);
        queue_word(MODE_ENC_G, 64'h0008_0000_0000_0000);
        queue_word(MODE_ENC_G, 64'hFFF0_0000_0000_0000);
        queue_word(MODE_ENC_G, 64'h7FEF_FFFF_FFFF_FFFF);
        queue_word(MODE_UNUSED_6, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_word(MODE_UNUSED_7, 64'h1234_5678_9ABC_DEF0);
        for (int i = 0; i < 650; i++) begin
            m = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            queue_word(m, (m >= MODE_ENC_F && m <= MODE_ENC_G) ? rand_double()
                                                              : rand_legacy(m));
        end
        stim_done = 1'b1;
    end

    // Reset, cycle count and the calm stretch with no idling.
    initial begin
        aresetn   = 1'b0;
        calm      = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        calm   <= (cycles > 300 && cycles < 500);
    end

    // Drive input transfers from the pending queue with random gaps.
    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cycles        = 0;
        mismatches    = 0;
        words_checked = 0;
    end

    always @(posedge aclk) begin
        conv_item_t it;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                it.mode = s_axis_tuser;
                it.word = s_axis_tdata;
                expected_words.push_back(convert_word(it));
                mode_count[it.mode] = mode_count[it.mode] + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_words.size() > 0 && (calm || $urandom_range(0, 99) >= 30)) begin
                    it = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= it.mode;
                    s_axis_tdata  <= it.word;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 30);
        end
    end

    // Check each output transfer against the oldest expected word.
    always @(posedge aclk) begin
        logic [63:0] want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected output transfer: %h", m_axis_tdata);
            end else begin
                want = expected_words.pop_front();
                words_checked = words_checked + 1;
                if (want !== m_axis_tdata) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("data_out mismatch: expected %h actual %h",
                                 want, m_axis_tdata);
                end
            end
        end
    end

    // Wait for drain, then report.
    initial begin
        wait (stim_done);
        while ((pending_words.size() > 0 || s_axis_tvalid || expected_words.size() > 0)
               && cycles < CycleLimit)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (cycles >= CycleLimit || expected_words.size() > 0) begin
            $display("timeout or leftover expectations: %0d", expected_words.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            $display("checked %0d words: decF %0d decD %0d decG %0d encF %0d encD %0d encG %0d",
                     words_checked, mode_count[0], mode_count[1], mode_count[2],
                     mode_count[3], mode_count[4], mode_count[5]);
            $display("unused modes %0d, mismatches %0d", mode_count[6] + mode_count[7],
                     mismatches);
            if (mismatches == 0)
                $display("Regression PASS");
            else
                $display("Regression FAIL");
            $finish;
        end
    end

endmodule
